// ===== rtl/bia_pkg.sv =====
// ----------------------------------------------------------------------------
// bia_pkg: shared definitions for the bitmap ID allocator
// Sizes, item kind codes and result status codes.
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int MAP_BITS   = 256;
  localparam int WORD_W     = 8;
  localparam int WORDS      = MAP_BITS / WORD_W;
  localparam int BIT_IDX_W  = $clog2(WORD_W);
  localparam int WORD_IDX_W = $clog2(WORDS);
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;

  localparam logic [CNT_W-1:0] TOTAL_BITS_RST = CNT_W'(256);

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_QUERY   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_USED  = 2'd3
  } status_e;

endpackage

// ===== rtl/bia_ram.sv =====
// ----------------------------------------------------------------------------
// bia_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bitmap_id_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_id_allocator: find-first-free slot allocator
// Bitmap of used slots kept in a byte-wide RAM, scanned one word a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind_i/index_i and raise start; the transaction is
//   taken at a clock edge with start high and busy low. kind 0 allocates the
//   first free slot at or above index_i, kind 1 releases slot index_i, kind 2
//   queries slot index_i.
//   Result channel: done_o pulses for one cycle with status_o, slot_o and
//   in_use_o. There is no back-pressure; the receiver must take it.
//   Config: cfg_we_i writes cfg_wdata_i into total_bits (active slot count,
//   saturated to 256). Write only while the block is idle; the map is kept.
// Timing:
//   Items rejected up front (start past the end, out of range, unused kind)
//   answer in the cycle after the accept edge and leave busy low.
//   Release and query read one RAM word through the registered port, then register the result.
//   Allocate reads one 8-bit word per cycle through the registered RAM port,
//   from the start word until a word with an eligible free bit or the last
//   active word. busy stays high during the scan; a new command can be
//   taken in the cycle that done_o is high.
// Reset:
//   rst_ni clears the per-word valid flags (32 flops), so every slot reads as
//   free at once; no clearing pass. total_bits returns to 256.
// ----------------------------------------------------------------------------
module bitmap_id_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind_i,
  input  logic [bia_pkg::IDX_W-1:0]  index_i,
  input  logic                       cfg_we_i,
  input  logic [bia_pkg::CNT_W-1:0]  cfg_wdata_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [bia_pkg::IDX_W-1:0]  slot_o,
  output logic                       in_use_o
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  localparam int WORD_W     = bia_pkg::WORD_W;
  localparam int BIT_IDX_W  = bia_pkg::BIT_IDX_W;
  localparam int WORD_IDX_W = bia_pkg::WORD_IDX_W;
  localparam int IDX_W      = bia_pkg::IDX_W;
  localparam int CNT_W      = bia_pkg::CNT_W;

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          total_q;
  logic [CNT_W-1:0]          n_act;
  bia_pkg::kind_e            kind_q, kind_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [CNT_W-1:0]          n_q, n_d;
  logic [WORD_IDX_W-1:0]     ptr_q, ptr_d;
  logic [bia_pkg::WORDS-1:0] valid_q;

  logic                      done_q, done_d;
  logic [1:0]                status_q, status_d;
  logic [IDX_W-1:0]          slot_q, slot_d;
  logic                      in_use_q, in_use_d;

  logic                      accept;
  logic                      re;
  logic [WORD_IDX_W-1:0]     raddr;
  logic                      we;
  logic [WORD_W-1:0]         wdata;
  logic [WORD_W-1:0]         rdata;
  logic [WORD_W-1:0]         word;
  logic [WORD_W-1:0]         free;
  logic                      found;
  logic [BIT_IDX_W-1:0]      fbit;
  logic                      sel_bit;
  logic [WORD_IDX_W-1:0]     last_w;
  logic [CNT_W-1:0]          n_m1;
  logic [CNT_W-1:0]          gidx;

  assign accept = start && !busy;
  assign busy   = (state_q == S_SCAN);

  // active count saturates at the map size
  assign n_act = (total_q > CNT_W'(bia_pkg::MAP_BITS)) ? CNT_W'(bia_pkg::MAP_BITS) : total_q;

  // word holding slot n-1 ends the scan (n >= 1 whenever scanning)
  assign n_m1   = n_q - CNT_W'(1);
  assign last_w = n_m1[IDX_W-1:BIT_IDX_W];

  // words never written since reset read as all free
  assign word    = valid_q[ptr_q] ? rdata : '0;
  assign sel_bit = word[idx_q[BIT_IDX_W-1:0]];

  // eligible free bits: at or above the start slot and below the active count
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      gidx    = CNT_W'({ptr_q, BIT_IDX_W'(b)});
      free[b] = !word[b] && (gidx >= CNT_W'(idx_q)) && (gidx < n_q);
    end
  end

  // priority encoder, lowest free bit wins
  always_comb begin
    found = 1'b0;
    fbit  = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free[b]) begin
        found = 1'b1;
        fbit  = BIT_IDX_W'(b);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    idx_d    = idx_q;
    n_d      = n_q;
    ptr_d    = ptr_q;
    done_d   = 1'b0;
    status_d = status_q;
    slot_d   = slot_q;
    in_use_d = in_use_q;
    re       = 1'b0;
    raddr    = ptr_q + WORD_IDX_W'(1);
    we       = 1'b0;
    wdata    = word;

    unique case (state_q)
      S_IDLE: begin
        raddr = index_i[IDX_W-1:BIT_IDX_W];
        if (accept) begin
          kind_d   = bia_pkg::kind_e'(kind_i);
          idx_d    = index_i;
          n_d      = n_act;
          ptr_d    = index_i[IDX_W-1:BIT_IDX_W];
          slot_d   = '0;
          in_use_d = 1'b0;
          if (kind_i == 2'(bia_pkg::KIND_ALLOC) ||
              kind_i == 2'(bia_pkg::KIND_RELEASE) ||
              kind_i == 2'(bia_pkg::KIND_QUERY)) begin
            if (CNT_W'(index_i) >= n_act) begin
              done_d   = 1'b1;
              status_d = (kind_i == 2'(bia_pkg::KIND_ALLOC)) ? 2'(bia_pkg::ST_NONE_FREE)
                                                             : 2'(bia_pkg::ST_RANGE);
            end else begin
              re      = 1'b1;
              state_d = S_SCAN;
            end
          end else begin
            // unused kind code
            done_d   = 1'b1;
            status_d = 2'(bia_pkg::ST_RANGE);
          end
        end
      end
      S_SCAN: begin
        case (kind_q)
          bia_pkg::KIND_ALLOC: begin
            if (found) begin
              we       = 1'b1;
              wdata    = word | (WORD_W'(1) << fbit);
              done_d   = 1'b1;
              status_d = 2'(bia_pkg::ST_OK);
              slot_d   = {ptr_q, fbit};
              state_d  = S_IDLE;
            end else if (ptr_q == last_w) begin
              done_d   = 1'b1;
              status_d = 2'(bia_pkg::ST_NONE_FREE);
              state_d  = S_IDLE;
            end else begin
              re    = 1'b1;
              ptr_d = ptr_q + WORD_IDX_W'(1);
            end
          end
          bia_pkg::KIND_RELEASE: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
            if (sel_bit) begin
              we       = 1'b1;
              wdata    = word & ~(WORD_W'(1) << idx_q[BIT_IDX_W-1:0]);
              status_d = 2'(bia_pkg::ST_OK);
            end else begin
              status_d = 2'(bia_pkg::ST_NOT_USED);
            end
          end
          bia_pkg::KIND_QUERY: begin
            done_d   = 1'b1;
            state_d  = S_IDLE;
            status_d = 2'(bia_pkg::ST_OK);
            in_use_d = sel_bit;
          end
          default: begin
            done_d   = 1'b1;
            state_d  = S_IDLE;
            status_d = 2'(bia_pkg::ST_RANGE);
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      total_q  <= bia_pkg::TOTAL_BITS_RST;
      valid_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (we) begin
        valid_q[ptr_q] <= 1'b1;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    idx_q    <= idx_d;
    n_q      <= n_d;
    ptr_q    <= ptr_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    in_use_q <= in_use_d;
  end

  bia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (bia_pkg::WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ptr_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign done_o   = done_q;
  assign status_o = status_q;
  assign slot_o   = slot_q;
  assign in_use_o = in_use_q;

endmodule

// ===== rtl/bia_checker.sv =====
// ----------------------------------------------------------------------------
// bia_checker: port-level checks for the bitmap ID allocator
// Watches command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module bia_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                kind_i,
  input logic                      done_o,
  input logic [1:0]                status_o,
  input logic [bia_pkg::IDX_W-1:0] slot_o,
  input logic                      in_use_o
);

  // every accepted transaction either answers next cycle or starts a scan
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted command neither answered nor scanning");

  // no result while a scan is still running
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result strobe during scan");

  // unused kind is answered at once as out of range
  a_bad_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == 2'd3) |=>
      (done_o && status_o == 2'(bia_pkg::ST_RANGE) && slot_o == '0 && !in_use_o))
    else $error("unused kind not rejected");

  // slot and in_use only carry data on success
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != 2'(bia_pkg::ST_OK)) |-> (slot_o == '0 && !in_use_o))
    else $error("nonzero payload on failed transaction");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .kind_i   (kind_i),
  .done_o   (done_o),
  .status_o (status_o),
  .slot_o   (slot_o),
  .in_use_o (in_use_o)
);
